[rtl/jfsp_pkg.sv]
// Package for the JPEG frame size parser: codes, constants and shared types.
`default_nettype none

package jfsp_pkg;

    localparam int DATA_W   = 8;
    localparam int DIM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int HDR_IDX_W = 3;

    localparam logic [DATA_W-1:0] MARK_FILL = 8'hFF;
    localparam logic [DATA_W-1:0] MARK_SOI  = 8'hD8;
    localparam logic [DATA_W-1:0] MARK_SOF0 = 8'hC0;
    localparam logic [DIM_W-1:0]  MIN_SEG_LEN = 16'd2;

    // Byte positions inside the frame header, counted after the marker
    localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_HI = 3'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_LO = 3'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_HI  = 3'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_LO  = 3'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_NCOMP     = 3'd7;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND   = 2'd0,
        STATUS_NO_SOI  = 2'd1,
        STATUS_TRUNC   = 2'd2,
        STATUS_INVALID = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_SEEK   = 3'd0,
        PH_FILL   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_SKIP   = 3'd4,
        PH_FRAME  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              stream_end;
    } item_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } result_t;

endpackage

`default_nettype wire

[rtl/jfsp_in_stage.sv]
// Input register of the JPEG frame size parser.
`default_nettype none

module jfsp_in_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [jfsp_pkg::DATA_W-1:0]   s_data_byte,
    input  wire logic                          s_stream_end,
    input  wire logic                          step,
    output logic                               item_valid,
    output jfsp_pkg::item_t                    item
);

    logic            valid_reg;
    logic            valid_next;
    jfsp_pkg::item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || step;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.data_byte  <= s_data_byte;
            item_reg.stream_end <= s_stream_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/jfsp_core.sv]
// Marker scanner and frame header decoder, one byte per step.
`default_nettype none

module jfsp_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire jfsp_pkg::item_t  item,
    output jfsp_pkg::result_t     result
);

    jfsp_pkg::phase_t                    phase_reg, phase_next;
    logic                                first_reg, first_next;
    logic                                verdict_reg, verdict_next;
    logic [jfsp_pkg::DIM_W-1:0]          skip_reg, skip_next;
    logic [jfsp_pkg::DATA_W-1:0]         len_hi_reg, len_hi_next;
    logic [jfsp_pkg::HDR_IDX_W-1:0]      idx_reg, idx_next;
    logic [jfsp_pkg::DIM_W-1:0]          width_reg, width_next;
    logic [jfsp_pkg::DIM_W-1:0]          height_reg, height_next;
    logic [jfsp_pkg::DIM_W-1:0]          seg_len;
    logic [jfsp_pkg::DATA_W-1:0]         b;

    assign b       = item.data_byte;
    assign seg_len = {len_hi_reg, b};

    // Next state
    always_comb begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        verdict_next = verdict_reg;
        skip_next    = skip_reg;
        len_hi_next  = len_hi_reg;
        idx_next     = idx_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        if (item.stream_end) begin
            phase_next   = jfsp_pkg::PH_SEEK;
            first_next   = 1'b1;
            verdict_next = 1'b0;
            skip_next    = '0;
            len_hi_next  = '0;
            idx_next     = '0;
            width_next   = '0;
            height_next  = '0;
        end else if (!verdict_reg) begin
            unique case (phase_reg)
                jfsp_pkg::PH_FILL: begin
                    if (b != jfsp_pkg::MARK_FILL) begin
                        if (first_reg) begin
                            first_next = 1'b0;
                            if (b != jfsp_pkg::MARK_SOI) begin
                                verdict_next = 1'b1;
                            end else begin
                                phase_next = jfsp_pkg::PH_SEEK;
                            end
                        end else if (b == jfsp_pkg::MARK_SOF0) begin
                            phase_next  = jfsp_pkg::PH_FRAME;
                            idx_next    = '0;
                            width_next  = '0;
                            height_next = '0;
                        end else begin
                            phase_next = jfsp_pkg::PH_LEN_HI;
                        end
                    end
                end
                jfsp_pkg::PH_LEN_HI: begin
                    len_hi_next = b;
                    phase_next  = jfsp_pkg::PH_LEN_LO;
                end
                jfsp_pkg::PH_LEN_LO: begin
                    if (seg_len <= jfsp_pkg::MIN_SEG_LEN) begin
                        phase_next = jfsp_pkg::PH_SEEK;
                    end else begin
                        skip_next  = seg_len - jfsp_pkg::MIN_SEG_LEN;
                        phase_next = jfsp_pkg::PH_SKIP;
                    end
                end
                jfsp_pkg::PH_SKIP: begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == jfsp_pkg::DIM_W'(1)) begin
                        phase_next = jfsp_pkg::PH_SEEK;
                    end
                end
                jfsp_pkg::PH_FRAME: begin
                    if (idx_reg == jfsp_pkg::HDR_HEIGHT_HI ||
                        idx_reg == jfsp_pkg::HDR_HEIGHT_LO) begin
                        height_next = {height_reg[jfsp_pkg::DIM_W-jfsp_pkg::DATA_W-1:0], b};
                    end else if (idx_reg == jfsp_pkg::HDR_WIDTH_HI ||
                                 idx_reg == jfsp_pkg::HDR_WIDTH_LO) begin
                        width_next = {width_reg[jfsp_pkg::DIM_W-jfsp_pkg::DATA_W-1:0], b};
                    end
                    if (idx_reg == jfsp_pkg::HDR_NCOMP) begin
                        verdict_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                default: begin
                    phase_next = (b == jfsp_pkg::MARK_FILL) ? jfsp_pkg::PH_FILL
                                                            : jfsp_pkg::PH_SEEK;
                end
            endcase
        end
    end

    // Result of the current byte
    always_comb begin
        result.valid  = 1'b0;
        result.status = jfsp_pkg::STATUS_FOUND;
        result.width  = '0;
        result.height = '0;
        if (item.stream_end) begin
            result.valid  = !verdict_reg;
            result.status = jfsp_pkg::STATUS_TRUNC;
        end else if (!verdict_reg) begin
            if (phase_reg == jfsp_pkg::PH_FILL && b != jfsp_pkg::MARK_FILL &&
                first_reg && b != jfsp_pkg::MARK_SOI) begin
                result.valid  = 1'b1;
                result.status = jfsp_pkg::STATUS_NO_SOI;
            end else if (phase_reg == jfsp_pkg::PH_FRAME &&
                         idx_reg == jfsp_pkg::HDR_NCOMP) begin
                result.valid  = 1'b1;
                result.status = jfsp_pkg::STATUS_FOUND;
                result.width  = width_reg;
                result.height = height_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= jfsp_pkg::PH_SEEK;
            first_reg   <= 1'b1;
            verdict_reg <= 1'b0;
            skip_reg    <= '0;
            len_hi_reg  <= '0;
            idx_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            verdict_reg <= verdict_next;
            skip_reg    <= skip_next;
            len_hi_reg  <= len_hi_next;
            idx_reg     <= idx_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
        end
    end

endmodule

`default_nettype wire

[rtl/jfsp_out_stage.sv]
// Result register of the JPEG frame size parser.
`default_nettype none

module jfsp_out_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step,
    input  wire jfsp_pkg::result_t               result,
    output logic                                 free,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [jfsp_pkg::STATUS_W-1:0]        m_status,
    output logic [jfsp_pkg::DIM_W-1:0]           m_image_width,
    output logic [jfsp_pkg::DIM_W-1:0]           m_image_height
);

    logic                         valid_reg, valid_next;
    logic                         load;
    jfsp_pkg::status_t            status_reg;
    logic [jfsp_pkg::DIM_W-1:0]   width_reg;
    logic [jfsp_pkg::DIM_W-1:0]   height_reg;

    assign free       = !valid_reg || m_ready;
    assign load       = step && result.valid;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= result.status;
            width_reg  <= result.width;
            height_reg <= result.height;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = status_reg;
    assign m_image_width  = width_reg;
    assign m_image_height = height_reg;

endmodule

`default_nettype wire

[rtl/jpeg_frame_size_parser.sv]
// Top level of the JPEG frame size parser.
//
//   channel | direction | payload                                  | handshake
//   s_      | in        | data_byte[7:0], stream_end               | s_valid / s_ready
//   m_      | out       | status[1:0], image_width, image_height   | m_valid / m_ready
//
// One byte per cycle unless a result waits on m_ready; bytes and results are registered.
// The loop that sets the rate is the parser state update.
// Synchronous active-low reset clears all control state and the parser.
// An m_ stall holds the byte in the input register; s_ready falls only while
// a result waits in the output register and m_ready is low.
`default_nettype none

module jpeg_frame_size_parser (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [jfsp_pkg::DATA_W-1:0]     s_data_byte,
    input  wire logic                            s_stream_end,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [jfsp_pkg::STATUS_W-1:0]        m_status,
    output logic [jfsp_pkg::DIM_W-1:0]           m_image_width,
    output logic [jfsp_pkg::DIM_W-1:0]           m_image_height
);

    logic               item_valid;
    logic               out_free;
    logic               step;
    jfsp_pkg::item_t    item;
    jfsp_pkg::result_t  result;

    assign step = item_valid && out_free;

    jfsp_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_stream_end (s_stream_end),
        .step         (step),
        .item_valid   (item_valid),
        .item         (item)
    );

    jfsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .result  (result)
    );

    jfsp_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .result         (result),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height)
    );

endmodule

`default_nettype wire

[rtl/jfsp_checker.sv]
// Port-level checks for the JPEG frame size parser, bound to the top level.
`default_nettype none

module jfsp_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic [jfsp_pkg::STATUS_W-1:0]   m_status,
    input  wire logic [jfsp_pkg::DIM_W-1:0]      m_image_width,
    input  wire logic [jfsp_pkg::DIM_W-1:0]      m_image_height
);

    // A stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_image_width) && $stable(m_image_height))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != jfsp_pkg::STATUS_INVALID)
        else $error("status code out of range");

    a_dims_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != jfsp_pkg::STATUS_FOUND |->
        m_image_width == '0 && m_image_height == '0)
        else $error("dimensions nonzero on failure status");

    // Input only backs up behind a waiting result
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && !$past(!aresetn))
        else $error("input stalled without a waiting result");

endmodule

bind jpeg_frame_size_parser jfsp_checker u_jfsp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_image_width  (m_image_width),
    .m_image_height (m_image_height)
);

`default_nettype wire

[verif/jpeg_frame_size_parser_tb.sv]
// Self-checking testbench for the JPEG frame size parser: byte streams in, frame sizes checked.
`timescale 1ns / 1ps

module jpeg_frame_size_parser_tb;

    import jfsp_pkg::*;

    localparam int ITEM_TARGET   = 900;
    localparam int HOLD_CYCLES   = 200;
    localparam int BURST_ITEMS   = 30;
    localparam int TAIL_CYCLES   = 20;

    typedef struct {
        status_t          status;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } frame_size_t;

    typedef struct {
        logic [DATA_W-1:0] data_b;
        logic              is_end;
    } stream_item_t;

    class frame_size_scoreboard;
        phase_t              ph;
        bit                  first_mark;
        bit                  done;
        logic [DIM_W-1:0]    skip_cnt;
        logic [DATA_W-1:0]   len_hi;
        logic [HDR_IDX_W-1:0] hdr_idx;
        logic [DIM_W-1:0]    wid;
        logic [DIM_W-1:0]    hgt;
        frame_size_t         expected_sizes[$];
        int                  predicted;
        int                  errors;

        function new();
            restart();
            predicted = 0;
            errors    = 0;
        endfunction

        function void restart();
            ph         = PH_SEEK;
            first_mark = 1'b1;
            done       = 1'b0;
            skip_cnt   = '0;
            len_hi     = '0;
            hdr_idx    = '0;
            wid        = '0;
            hgt        = '0;
        endfunction

        function void push_size(status_t st, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
            frame_size_t fs;
            fs.status = st;
            fs.width  = w;
            fs.height = h;
            expected_sizes.push_back(fs);
            predicted++;
        endfunction

        // Advance the parser model by one accepted transaction
        function void take_byte(logic [DATA_W-1:0] b, logic e);
            logic [DIM_W-1:0] seg_len;
            if (e) begin
                if (!done)
                    push_size(STATUS_TRUNC, '0, '0);
                restart();
                return;
            end
            if (done)
                return;
            case (ph)
                PH_FILL: begin
                    if (b != MARK_FILL) begin
                        if (first_mark) begin
                            first_mark = 1'b0;
                            if (b != MARK_SOI) begin
                                done = 1'b1;
                                push_size(STATUS_NO_SOI, '0, '0);
                            end else begin
                                ph = PH_SEEK;
                            end
                        end else if (b == MARK_SOF0) begin
                            ph      = PH_FRAME;
                            hdr_idx = '0;
                            wid     = '0;
                            hgt     = '0;
                        end else begin
                            ph = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI: begin
                    len_hi = b;
                    ph     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    seg_len = {len_hi, b};
                    if (seg_len <= MIN_SEG_LEN) begin
                        ph = PH_SEEK;
                    end else begin
                        skip_cnt = seg_len - MIN_SEG_LEN;
                        ph       = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_cnt = skip_cnt - 1'b1;
                    if (skip_cnt == '0)
                        ph = PH_SEEK;
                end
                PH_FRAME: begin
                    if (hdr_idx == HDR_HEIGHT_HI || hdr_idx == HDR_HEIGHT_LO)
                        hgt = {hgt[7:0], b};
                    else if (hdr_idx == HDR_WIDTH_HI || hdr_idx == HDR_WIDTH_LO)
                        wid = {wid[7:0], b};
                    if (hdr_idx == HDR_NCOMP) begin
                        done = 1'b1;
                        push_size(STATUS_FOUND, wid, hgt);
                    end else begin
                        hdr_idx = hdr_idx + 1'b1;
                    end
                end
                default: begin
                    ph = (b == MARK_FILL) ? PH_FILL : PH_SEEK;
                end
            endcase
        endfunction

        function void check_size(logic [STATUS_W-1:0] st, logic [DIM_W-1:0] w,
                                 logic [DIM_W-1:0] h);
            frame_size_t fs;
            if (expected_sizes.size() == 0) begin
                $display("%0t: unexpected result: expected none, got status %0d width %0d height %0d",
                         $time, st, w, h);
                errors++;
                return;
            end
            fs = expected_sizes.pop_front();
            if (fs.status !== st) begin
                $display("%0t: status mismatch: expected %0d, got %0d", $time, fs.status, st);
                errors++;
            end
            if (fs.width !== w) begin
                $display("%0t: width mismatch: expected %0d, got %0d", $time, fs.width, w);
                errors++;
            end
            if (fs.height !== h) begin
                $display("%0t: height mismatch: expected %0d, got %0d", $time, fs.height, h);
                errors++;
            end
        endfunction

        function int pending();
            return expected_sizes.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_data_byte;
    logic                  s_stream_end;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [DIM_W-1:0]      m_image_width;
    logic [DIM_W-1:0]      m_image_height;

    frame_size_scoreboard  sb;
    stream_item_t          stream_q[$];
    int                    idle_pct;
    int                    stall_pct;
    int                    items_sent;
    bit                    hold_req;

    jpeg_frame_size_parser uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_stream_end   (s_stream_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.take_byte(s_data_byte, s_stream_end);
            if (m_valid && m_ready)
                sb.check_size(m_status, m_image_width, m_image_height);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void add_byte(logic [DATA_W-1:0] b);
        stream_item_t it;
        it.data_b = b;
        it.is_end = 1'b0;
        stream_q.push_back(it);
    endfunction

    function automatic void add_end();
        stream_item_t it;
        it.data_b = DATA_W'($urandom);
        it.is_end = 1'b1;
        stream_q.push_back(it);
    endfunction

    function automatic void add_fills();
        repeat (($urandom_range(99) < 20) ? $urandom_range(3, 2) : 1)
            add_byte(MARK_FILL);
    endfunction

    function automatic logic [DATA_W-1:0] junk_byte();
        return DATA_W'($urandom_range(254));
    endfunction

    // Header bytes lean on the extremes so min/max sizes show up
    function automatic logic [DATA_W-1:0] header_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return 8'h00;
        if (r < 50)
            return 8'hFF;
        return DATA_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] segment_code();
        int r;
        logic [DATA_W-1:0] c;
        r = $urandom_range(99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return MARK_SOI;
        do
            c = DATA_W'($urandom);
        while (c == MARK_FILL || c == MARK_SOF0);
        return c;
    endfunction

    task automatic send_item(input logic [DATA_W-1:0] b, input logic e);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_stream_end <= e;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) begin
            send_item(stream_q[i].data_b, stream_q[i].is_end);
            items_sent++;
        end
        stream_q.delete();
    endtask

    // Mostly well-formed files with random content; some noise and cut-off files
    task automatic build_stream();
        int               kind;
        int               nseg;
        int               r;
        int               cut;
        int               i;
        logic [DIM_W-1:0] seg_len;
        kind = $urandom_range(99);
        if (kind >= 80) begin
            repeat ($urandom_range(8))
                add_byte(DATA_W'($urandom));
            add_end();
            return;
        end
        repeat ($urandom_range(2))
            add_byte(junk_byte());
        add_fills();
        add_byte(MARK_SOI);
        nseg = $urandom_range(3);
        for (i = 0; i < nseg; i++) begin
            repeat ($urandom_range(1))
                add_byte(junk_byte());
            add_fills();
            add_byte(segment_code());
            r = $urandom_range(99);
            if (r < 10) begin
                seg_len = DIM_W'($urandom_range(2));
            end else if (r < 15) begin
                // huge length, file ends inside the segment
                add_byte(DATA_W'($urandom_range(255, 1)));
                add_byte(DATA_W'($urandom));
                repeat ($urandom_range(5))
                    add_byte(DATA_W'($urandom));
                add_end();
                return;
            end else if (r < 18) begin
                seg_len = DIM_W'($urandom_range(300, 100));
            end else begin
                seg_len = DIM_W'($urandom_range(14, 3));
            end
            add_byte(seg_len[15:8]);
            add_byte(seg_len[7:0]);
            if (seg_len > MIN_SEG_LEN)
                repeat (seg_len - MIN_SEG_LEN)
                    add_byte(DATA_W'($urandom));
        end
        add_fills();
        add_byte(MARK_SOF0);
        repeat (8)
            add_byte(header_byte());
        repeat ($urandom_range(3))
            add_byte(DATA_W'($urandom));
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(stream_q.size() - 1);
            while (stream_q.size() > cut)
                void'(stream_q.pop_back());
        end
        add_end();
    endtask

    initial begin
        int stage;
        bit burst_done;
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        s_stream_end = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        items_sent   = 0;
        hold_req     = 1'b0;
        burst_done   = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // End with no marker at all
        add_end();
        // Wrong first marker, then ignored bytes and a silent end
        add_byte(MARK_FILL); add_byte(8'h00); add_byte(MARK_FILL); add_end();
        // Short lengths, zero and SOI codes as segments, extra fill, maximum size
        add_byte(MARK_FILL); add_byte(MARK_SOI);
        add_byte(MARK_FILL); add_byte(8'h00); add_byte(8'h00); add_byte(8'h01);
        add_byte(MARK_FILL); add_byte(MARK_SOI); add_byte(8'h00); add_byte(8'h03);
        add_byte(8'hAA);
        add_byte(MARK_FILL); add_byte(MARK_FILL); add_byte(MARK_SOF0);
        add_byte(8'h00); add_byte(8'h11); add_byte(8'h08);
        add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'h03); add_end();
        // File ends inside a long segment
        add_byte(MARK_FILL); add_byte(MARK_SOI); add_byte(MARK_FILL); add_byte(8'hE1);
        add_byte(8'hFF); add_byte(8'h10); add_byte(8'hAB); add_end();
        send_stream();

        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            stage = (items_sent * 4) / ITEM_TARGET;
            if (stage > 3)
                stage = 3;
            case (stage)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (stage == 2 && !burst_done) begin
                // Back-to-back end transactions while the receiver holds off
                burst_done = 1'b1;
                hold_req   = 1'b1;
                repeat (BURST_ITEMS)
                    add_end();
                send_stream();
            end
            build_stream();
            send_stream();
        end
        s_valid   <= 1'b0;
        stall_pct = 0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
rtl/jfsp_pkg.sv
rtl/jfsp_in_stage.sv
rtl/jfsp_core.sv
rtl/jfsp_out_stage.sv
rtl/jpeg_frame_size_parser.sv
rtl/jfsp_checker.sv
verif/jpeg_frame_size_parser_tb.sv
